// ===== rtl/shc_pkg.sv =====
// Package for the SHA-512 hash-chain random byte generator.
// Holds the round constants, initial hash words and the SHA-512 helper functions.
// No dependencies.
package shc_pkg;

	localparam int unsigned WordW   = 64;
	localparam int unsigned NumWords = 8;
	localparam int unsigned NumRounds = 80;

	typedef logic [WordW-1:0] word_t;

	localparam logic CmdLoad = 1'b0;
	localparam logic CmdGen  = 1'b1;

	function automatic word_t round_k(input logic [6:0] t);
		word_t k;
		case (t)
			7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
			7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
			7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
			7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
			7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic word_t start_h(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 64'h6a09e667f3bcc908;
			3'd1: h = 64'hbb67ae8584caa73b;
			3'd2: h = 64'h3c6ef372fe94f82b;
			3'd3: h = 64'ha54ff53a5f1d36f1;
			3'd4: h = 64'h510e527fade682d1;
			3'd5: h = 64'h9b05688c2b3e6c1f;
			3'd6: h = 64'h1f83d9abfb41bd6b;
			default: h = 64'h5be0cd19137e2179;
		endcase
		return h;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic word_t sig1(input word_t x);
		return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

endpackage

// ===== rtl/shc_round.sv =====
// SHA-512 compression engine: one round per cycle over a sixteen-word schedule window.
// Depends on shc_pkg.
module shc_round (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  load_en,
	input  shc_pkg::word_t        load_word,
	output logic                  done,
	output shc_pkg::word_t        digest [8]
);
	import shc_pkg::*;

	word_t    w_q [16];
	word_t    v_q [8];
	logic [6:0] rnd_q;
	logic       busy_q;
	logic [2:0] fill_q;
	word_t    t1;
	word_t    t2;
	word_t    w_new;
	word_t    maj;
	word_t    ch;

	always_comb begin
		w_new = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + bsig1(v_q[4]) + ch + round_k(rnd_q) + w_q[0];
		t2    = bsig0(v_q[0]) + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			fill_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (load_en) begin
				fill_q <= fill_q + 3'd1;
			end
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
				fill_q <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'(NumRounds - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// The window is loaded with the eight chain words in order; padding is constant.
	always_ff @(posedge clk) begin
		if (load_en) begin
			w_q[fill_q] <= load_word;
		end
		if (start) begin
			w_q[8] <= 64'h8000000000000000;
			for (int i = 9; i < 15; i++) w_q[i] <= '0;
			w_q[15] <= 64'd512;
			for (int i = 0; i < 8; i++) v_q[i] <= start_h(3'(i));
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) digest[i] = start_h(3'(i)) + v_q[i];
	end

endmodule

// ===== rtl/sha512_hash_chain_random_bytes_top.sv =====
// Top level of the SHA-512 hash-chain random byte generator.
// Depends on shc_pkg and shc_round.
//
// Usage: one input channel (in_valid/in_stall) carries transactions that
// either load one 64-bit seed word into the chain value (command 0) or
// generate one hash block (command 1). The output channel
// (out_valid/out_stall) carries one transaction per delivered word, with
// valid_bytes and a last flag on the final word of a block.
// The chain value lives in an eight-entry synchronous memory with a
// registered read port. A load is a single write.
// A generate reads the eight words out of the memory into the schedule
// window, runs 80 rounds of the single round unit, writes the eight new
// words back, and then offers the delivered words one at a time, each
// only after the previous one is taken. A generate therefore holds the
// input stalled until its last word is taken, including any output
// stall; the 80-round loop dominates when the receiver does not stall.
// Bytes of a block beyond bytes_wanted are dropped; zero bytes wanted gives
// nothing and leaves the chain value unchanged; above 64 saturates to 64.
// The chain write-back completes before the first word is offered; the
// output register holds its word while the receiver stalls.
// Reset clears the control state; the memory is tracked by eight valid bits
// so unwritten entries read as zero, with no clearing pass.
module sha512_hash_chain_random_bytes_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [2:0]  word_index,
	input  logic [63:0] seed_word,
	input  logic [6:0]  bytes_wanted,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] random_word,
	output logic [3:0]  valid_bytes,
	output logic        last
);
	import shc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_HASH,
		ST_WRITE,
		ST_OUT
	} state_t;

	state_t     state_q;
	word_t      mem [8];
	logic [7:0] mem_ok_q;
	word_t      rd_data_q;
	logic       rd_ok_q;
	logic [3:0] cnt_q;
	logic [6:0] want_q;
	logic       rd_pend_q;
	logic       start;
	logic       load_en;
	logic       done;
	word_t      digest [8];
	logic       acc_in;
	logic       mem_we;
	logic [2:0] mem_waddr;
	word_t      mem_wdata;
	logic [2:0] mem_raddr;
	logic [6:0] left;

	assign in_stall = (state_q != ST_IDLE);
	assign acc_in   = in_valid && !in_stall;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_index;
		mem_wdata = seed_word;
		if (acc_in && command == CmdLoad) begin
			mem_we = 1'b1;
		end else if (state_q == ST_WRITE) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[2:0];
			mem_wdata = digest[cnt_q[2:0]];
		end
	end

	assign mem_raddr = cnt_q[2:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	assign load_en = rd_pend_q;
	assign start   = (state_q == ST_READ) && cnt_q == 4'd8 && rd_pend_q;

	shc_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.load_en   (load_en),
		.load_word (rd_ok_q ? rd_data_q : '0),
		.done      (done),
		.digest    (digest)
	);

	assign left = want_q - {1'b0, cnt_q[2:0], 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mem_ok_q    <= '0;
			cnt_q       <= '0;
			want_q      <= '0;
			rd_pend_q   <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_valid   <= 1'b0;
			random_word <= '0;
			valid_bytes <= '0;
			last        <= 1'b0;
		end else begin
			rd_pend_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (command == CmdLoad) begin
							mem_ok_q[word_index] <= 1'b1;
						end else if (bytes_wanted != 7'd0) begin
							want_q  <= (bytes_wanted > 7'd64) ? 7'd64 : bytes_wanted;
							cnt_q   <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (cnt_q != 4'd8) begin
						rd_ok_q   <= mem_ok_q[cnt_q[2:0]];
						rd_pend_q <= 1'b1;
						cnt_q     <= cnt_q + 4'd1;
					end else if (rd_pend_q) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					cnt_q <= '0;
					if (done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					mem_ok_q[cnt_q[2:0]] <= 1'b1;
					if (cnt_q == 4'd7) begin
						cnt_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_OUT: begin
					if (!out_valid) begin
						out_valid   <= 1'b1;
						random_word <= digest[cnt_q[2:0]];
						valid_bytes <= (left >= 7'd8) ? 4'd8 : left[3:0];
						last        <= (left <= 7'd8);
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output only appears while delivering a block.
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT)
		else $error("output valid outside delivery");
	// No input taken while the round unit is hashing a block.
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HASH) |-> !acc_in)
		else $error("input accepted during hash");
	// Round unit finishes only while waiting for it.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_HASH)
		else $error("round done out of place");

endmodule
